// ----- src/drawing_command_deframer_top_defines.svh -----
// Assertion macros shared by the drawing command deframer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef DRAWING_COMMAND_DEFRAMER_TOP_DEFINES_SVH
`define DRAWING_COMMAND_DEFRAMER_TOP_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define DCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define DCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dcd_pkg.sv -----
// Package for the drawing command deframer: opcodes, command kinds,
// frame lengths, BCD decode functions and inter-module structs. No dependencies.
package dcd_pkg;

    localparam int PAYLOAD_DEPTH = 13;

    localparam logic [7:0] OP_CIRCLE = 8'hA1;
    localparam logic [7:0] OP_RECT   = 8'hA2;
    localparam logic [7:0] OP_LINE   = 8'hA3;
    localparam logic [7:0] OP_FILL   = 8'hA4;
    localparam logic [7:0] OP_DATE   = 8'hA5;
    localparam logic [7:0] OP_CLEAR  = 8'hA6;
    localparam logic [7:0] OP_MIRROR = 8'hA7;
    localparam logic [7:0] OP_BUCKET = 8'hA8;

    localparam logic [2:0] KIND_CIRCLE = 3'd0;
    localparam logic [2:0] KIND_RECT   = 3'd1;
    localparam logic [2:0] KIND_LINE   = 3'd2;
    localparam logic [2:0] KIND_FILL   = 3'd3;
    localparam logic [2:0] KIND_DATE   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_MIRROR = 3'd6;
    localparam logic [2:0] KIND_BUCKET = 3'd7;

    typedef struct packed {
        logic                               emit;
        logic [2:0]                         kind;
        logic [PAYLOAD_DEPTH-1:0][7:0]      bytes;
    } dcd_frame_t;

    typedef struct packed {
        logic [2:0]  cmd_kind;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [13:0] arg_a;
        logic [13:0] arg_b;
        logic [13:0] arg_c;
        logic [19:0] color_value;
        logic [47:0] date_bcd;
    } dcd_result_t;

    function automatic logic [3:0] frame_len(input logic [2:0] kind);
        logic [3:0] len;
        case (kind)
            KIND_CIRCLE: len = 4'd9;
            KIND_RECT:   len = 4'd11;
            KIND_LINE:   len = 4'd13;
            KIND_FILL:   len = 4'd7;
            KIND_DATE:   len = 4'd13;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    // Nibbles weighted as they stand, so non-decimal digits wrap like the spec.
    function automatic logic [13:0] bcd16_to_bin(input logic [15:0] raw);
        logic [14:0] sum;
        sum = 15'(raw[3:0])
            + 15'(raw[7:4])   * 15'd10
            + 15'(raw[11:8])  * 15'd100
            + 15'(raw[15:12]) * 15'd1000;
        return sum[13:0];
    endfunction

    function automatic logic [19:0] bcd24_to_bin(input logic [23:0] raw);
        logic [20:0] sum;
        sum = 21'(raw[3:0])
            + 21'(raw[7:4])   * 21'd10
            + 21'(raw[11:8])  * 21'd100
            + 21'(raw[15:12]) * 21'd1000
            + 21'(raw[19:16]) * 21'd10000
            + 21'(raw[23:20]) * 21'd100000;
        return sum[19:0];
    endfunction

endpackage

// ----- src/dcd_frame_ctrl.sv -----
// Frame tracker: opcode detection, byte position and payload store.
// Depends on dcd_pkg and the deframer assertion macros.
`include "drawing_command_deframer_top_defines.svh"

module dcd_frame_ctrl
    import dcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output dcd_frame_t frame
);

    logic [2:0] kind_reg;
    logic [2:0] kind_next;
    logic       active_reg;
    logic       active_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       wr_en;
    logic [3:0] len;
    logic       is_open;
    logic       is_imm;
    logic [PAYLOAD_DEPTH-1:0][7:0] payload_reg;

    assign is_open = (rx_byte >= OP_CIRCLE) && (rx_byte <= OP_DATE);
    assign is_imm  = (rx_byte >= OP_CLEAR) && (rx_byte <= OP_BUCKET);
    assign len     = frame_len(kind_reg);

    always_comb
    begin
        kind_next   = kind_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        wr_en       = 1'b0;
        frame.emit  = 1'b0;
        frame.kind  = kind_reg;
        if (is_open)
        begin
            kind_next   = 3'(rx_byte - OP_CIRCLE);
            active_next = 1'b1;
            pos_next    = 4'd0;
        end
        else if (is_imm)
        begin
            active_next = 1'b0;
            pos_next    = 4'd0;
            frame.emit  = 1'b1;
            frame.kind  = KIND_CLEAR + 3'(rx_byte - OP_CLEAR);
        end
        else if (active_reg)
        begin
            if (pos_reg >= len)
            begin
                pos_next = 4'd0;
            end
            else
            begin
                wr_en = 1'b1;
                if ((pos_reg + 4'd1) < len)
                begin
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    pos_next   = 4'd0;
                    frame.emit = 1'b1;
                end
            end
        end
        // Last byte is merged in so the completed frame is seen in the same cycle.
        for (int i = 0; i < PAYLOAD_DEPTH; i++)
        begin
            frame.bytes[i] = (wr_en && (pos_reg == 4'(i))) ? rx_byte : payload_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_CIRCLE;
            active_reg <= 1'b0;
            pos_reg    <= 4'd0;
        end
        else if (step)
        begin
            kind_reg   <= kind_next;
            active_reg <= active_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            payload_reg[pos_reg] <= rx_byte;
        end
    end

    `DCD_ASSERT_ALWAYS(a_pos_in_store, clk, !rst_n || (pos_reg < 4'(PAYLOAD_DEPTH)),
        "byte position past payload store")
    `DCD_ASSERT(a_idle_pos_zero, clk, rst_n, !active_reg |-> pos_reg == 4'd0,
        "byte position nonzero while idle")
    `DCD_ASSERT(a_frame_emit_active, clk, rst_n,
        (frame.emit && frame.kind <= KIND_DATE) |-> (active_reg && pos_reg == len - 4'd1),
        "frame emitted without a complete frame")

endmodule

// ----- src/dcd_cmd_decode.sv -----
// Command field extraction and BCD to binary conversion of a completed frame.
// Depends on dcd_pkg.
module dcd_cmd_decode
    import dcd_pkg::*;
(
    input  dcd_frame_t  frame,
    output dcd_result_t result
);

    logic [PAYLOAD_DEPTH-1:0][7:0] b;

    assign b = frame.bytes;

    always_comb
    begin
        result          = '0;
        result.cmd_kind = frame.kind;
        if (frame.kind <= KIND_DATE)
        begin
            result.pos_x = bcd16_to_bin({b[1], b[0]});
            result.pos_y = bcd16_to_bin({b[3], b[2]});
        end
        case (frame.kind)
            KIND_CIRCLE:
            begin
                result.arg_a       = bcd16_to_bin({b[5], b[4]});
                result.color_value = bcd24_to_bin({b[8], b[7], b[6]});
            end
            KIND_RECT:
            begin
                result.arg_a       = bcd16_to_bin({b[5], b[4]});
                result.arg_b       = bcd16_to_bin({b[7], b[6]});
                result.color_value = bcd24_to_bin({b[10], b[9], b[8]});
            end
            KIND_LINE:
            begin
                result.arg_a       = bcd16_to_bin({b[5], b[4]});
                result.arg_b       = bcd16_to_bin({b[7], b[6]});
                result.arg_c       = bcd16_to_bin({b[9], b[8]});
                result.color_value = bcd24_to_bin({b[12], b[11], b[10]});
            end
            KIND_FILL:
            begin
                result.color_value = bcd24_to_bin({b[6], b[5], b[4]});
            end
            KIND_DATE:
            begin
                result.date_bcd    = {b[9], b[8], b[7], b[6], b[5], b[4]};
                result.color_value = bcd24_to_bin({b[12], b[11], b[10]});
            end
            default:
            begin
                result.cmd_kind = frame.kind;
            end
        endcase
    end

endmodule

// ----- src/drawing_command_deframer_top.sv -----
// Drawing command deframer top level: input register, frame tracker,
// decoder and result register. Depends on dcd_pkg, dcd_frame_ctrl, dcd_cmd_decode.
//
// Takes one serial byte per item and emits at most one decoded drawing command
// per byte. Sustained rate is one byte per clock while the output is not
// stalled; each result passes the input register, then the result register. Input
// stall rises only when a byte is held in the input register while a
// finished result waits on a stalled output. Bytes 0xA1-0xA5 open a frame,
// 0xA6-0xA8 emit clear, mirror or magic bucket at once; coordinates, sizes
// and colour leave BCD-decoded, date bytes leave raw.
`include "drawing_command_deframer_top_defines.svh"

module drawing_command_deframer_top
    import dcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  cmd_kind,
    output logic [13:0] pos_x,
    output logic [13:0] pos_y,
    output logic [13:0] arg_a,
    output logic [13:0] arg_b,
    output logic [13:0] arg_c,
    output logic [19:0] color_value,
    output logic [47:0] date_bcd
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    dcd_result_t result_reg;
    dcd_result_t result_next;
    dcd_frame_t  frame;
    logic        adv;
    logic        step;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !adv;
    assign step     = s1_valid_reg && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    dcd_frame_ctrl u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .frame   (frame)
    );

    dcd_cmd_decode u_cmd_decode (
        .frame  (frame),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && frame.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && frame.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cmd_kind    = result_reg.cmd_kind;
    assign pos_x       = result_reg.pos_x;
    assign pos_y       = result_reg.pos_y;
    assign arg_a       = result_reg.arg_a;
    assign arg_b       = result_reg.arg_b;
    assign arg_c       = result_reg.arg_c;
    assign color_value = result_reg.color_value;
    assign date_bcd    = result_reg.date_bcd;

    `DCD_ASSERT(a_stall_needs_result, clk, rst_n,
        in_stall |-> (out_valid_reg && s1_valid_reg), "input stalled without a held result")
    `DCD_ASSERT(a_result_from_item, clk, rst_n,
        $rose(out_valid_reg) |-> $past(s1_valid_reg), "result without a registered item")
    `DCD_ASSERT(a_drain_empty, clk, rst_n,
        (out_valid_reg && !out_stall && !s1_valid_reg) |=> !out_valid_reg,
        "stale result after drain")

endmodule

// ----- tb/drawing_command_deframer_top_test.sv -----
// Self-checking testbench for drawing_command_deframer_top: a directed byte table, then random
// frames, noise and back-pressure, each command checked against an in-bench deframer.
// Depends on dcd_pkg and the deframer RTL.
module drawing_command_deframer_top_test
    import dcd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES [0:4] = '{9, 11, 13, 7, 13};
    localparam int RANDOM_ITEMS = 1800;
    localparam int LONG_HOLD = 64;

    typedef struct {
        logic [7:0]  rx;
        bit          typed;
        bit          has_cmd;
        dcd_result_t cmd;
    } byte_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  cmd_kind;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic [13:0] arg_a;
    logic [13:0] arg_b;
    logic [13:0] arg_c;
    logic [19:0] color_value;
    logic [47:0] date_bcd;

    // deframer state
    logic [2:0]  frame_kind = KIND_CIRCLE;
    bit          in_frame = 1'b0;
    int          next_pos = 0;
    logic [7:0]  frame_buf [0:12];

    dcd_result_t pending_cmds [$];
    byte_row_t   directed_rows [$];

    bit          typed_on = 1'b0;
    bit          typed_has = 1'b0;
    dcd_result_t typed_cmd;
    bit          steady = 1'b0;
    bit          hold_long = 1'b0;
    int          mismatches = 0;
    int          bytes_sent = 0;
    int          effective_items = 0;
    int          cmds_checked = 0;
    int          stalled_cycles = 0;
    int          kind_seen [0:7] = '{default: 0};

    drawing_command_deframer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd_kind    (cmd_kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .arg_a       (arg_a),
        .arg_b       (arg_b),
        .arg_c       (arg_c),
        .color_value (color_value),
        .date_bcd    (date_bcd)
    );

    always #2 clk = ~clk;

    // each nibble weighted by its decimal place as it stands
    function automatic logic [31:0] decimal_weigh(input logic [23:0] raw, input int digits);
        logic [31:0] sum;
        logic [31:0] weight;
        sum = 0;
        weight = 1;
        for (int i = 0; i < digits; i++)
        begin
            sum += 32'(raw[4*i +: 4]) * weight;
            weight *= 10;
        end
        return sum;
    endfunction

    function automatic logic [13:0] coord_at(input int at);
        logic [31:0] v;
        v = decimal_weigh({8'h00, frame_buf[at+1], frame_buf[at]}, 4);
        return v[13:0];
    endfunction

    function automatic logic [19:0] colour_at(input int at);
        logic [31:0] v;
        v = decimal_weigh({frame_buf[at+2], frame_buf[at+1], frame_buf[at]}, 6);
        return v[19:0];
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output dcd_result_t cmd,
                                        output bit effective);
        bit has;
        has = 1'b0;
        effective = 1'b1;
        cmd = '0;
        if (b >= OP_CIRCLE && b <= OP_DATE)
        begin
            frame_kind = 3'(b - OP_CIRCLE);
            in_frame = 1'b1;
            next_pos = 0;
        end
        else if (b >= OP_CLEAR && b <= OP_BUCKET)
        begin
            in_frame = 1'b0;
            next_pos = 0;
            cmd.cmd_kind = KIND_CLEAR + 3'(b - OP_CLEAR);
            has = 1'b1;
        end
        else if (!in_frame)
        begin
            effective = 1'b0;
        end
        else
        begin
            frame_buf[next_pos] = b;
            if (next_pos + 1 < FRAME_BYTES[frame_kind])
            begin
                next_pos++;
            end
            else
            begin
                next_pos = 0;
                has = 1'b1;
                cmd.cmd_kind = frame_kind;
                cmd.pos_x = coord_at(0);
                cmd.pos_y = coord_at(2);
                case (frame_kind)
                    KIND_CIRCLE:
                    begin
                        cmd.arg_a = coord_at(4);
                        cmd.color_value = colour_at(6);
                    end
                    KIND_RECT:
                    begin
                        cmd.arg_a = coord_at(4);
                        cmd.arg_b = coord_at(6);
                        cmd.color_value = colour_at(8);
                    end
                    KIND_LINE:
                    begin
                        cmd.arg_a = coord_at(4);
                        cmd.arg_b = coord_at(6);
                        cmd.arg_c = coord_at(8);
                        cmd.color_value = colour_at(10);
                    end
                    KIND_FILL:
                    begin
                        cmd.color_value = colour_at(4);
                    end
                    default:
                    begin
                        cmd.date_bcd = {frame_buf[9], frame_buf[8], frame_buf[7],
                                        frame_buf[6], frame_buf[5], frame_buf[4]};
                        cmd.color_value = colour_at(10);
                    end
                endcase
            end
        end
        return has;
    endfunction

    // payload byte: mostly decimal digits, otherwise any non-opcode value
    function automatic logic [7:0] frame_byte();
        logic [7:0] v;
        if ($urandom_range(0, 9) < 6)
        begin
            v = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        end
        else
        begin
            do
                v = 8'($urandom_range(0, 255));
            while (v >= OP_CIRCLE && v <= OP_BUCKET);
        end
        return v;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int          gap;
        bit          has;
        bit          effective;
        dcd_result_t cmd;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        has = deframe_byte(b, cmd, effective);
        if (effective)
            effective_items++;
        if (typed_on)
        begin
            has = typed_has;
            cmd = typed_cmd;
        end
        if (has)
            pending_cmds.push_back(cmd);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_cmds.size() != 0);
    endtask

    // receiver holds off while the sender keeps pushing one-byte commands
    task automatic flood_while_held();
        hold_long = 1'b1;
        steady = 1'b1;
        repeat (16) send_byte(OP_CLEAR + 8'($urandom_range(0, 2)));
        steady = 1'b0;
        drain();
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input bit has,
                           input dcd_result_t cmd);
        byte_row_t row;
        row.rx = b;
        row.typed = typed;
        row.has_cmd = has;
        row.cmd = cmd;
        directed_rows.push_back(row);
    endtask

    task automatic check_field(input string fname, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // receiver stall
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (!steady && ((out_valid && !out_stall) || $urandom_range(0, 7) == 0))
            begin
                n = $urandom_range(0, 8);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        dcd_result_t want;
        if (rst_n && in_valid && in_stall)
            stalled_cycles++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected command, kind %0d", $time, cmd_kind);
            end
            else
            begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                kind_seen[cmd_kind]++;
                check_field("cmd_kind", 48'(want.cmd_kind), 48'(cmd_kind));
                check_field("pos_x", 48'(want.pos_x), 48'(pos_x));
                check_field("pos_y", 48'(want.pos_y), 48'(pos_y));
                check_field("arg_a", 48'(want.arg_a), 48'(arg_a));
                check_field("arg_b", 48'(want.arg_b), 48'(arg_b));
                check_field("arg_c", 48'(want.arg_c), 48'(arg_c));
                check_field("color_value", 48'(want.color_value), 48'(color_value));
                check_field("date_bcd", want.date_bcd, date_bcd);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        dcd_result_t clr;
        dcd_result_t mir;
        dcd_result_t bkt;
        dcd_result_t full;
        logic [7:0]  op;
        int          sel;
        int          len;
        int          next_drain;
        bit          held_twice;

        clr = '0;
        clr.cmd_kind = KIND_CLEAR;
        mir = '0;
        mir.cmd_kind = KIND_MIRROR;
        bkt = '0;
        bkt.cmd_kind = KIND_BUCKET;
        full = '0;
        full.cmd_kind = KIND_FILL;
        full.pos_x = 14'd9999;
        full.pos_y = 14'd9999;
        full.color_value = 20'd999999;

        // idle bytes, one-byte commands, all-nines fill, back-to-back fill of
        // non-decimal nibbles, opcodes restarting frames, command inside payload
        add_row(8'h00, 1, 0, '0);
        add_row(8'hFF, 1, 0, '0);
        add_row(OP_CLEAR, 1, 1, clr);
        add_row(OP_MIRROR, 1, 1, mir);
        add_row(OP_BUCKET, 1, 1, bkt);
        add_row(OP_FILL, 1, 0, '0);
        repeat (6) add_row(8'h99, 0, 0, '0);
        add_row(8'h99, 1, 1, full);
        repeat (7) add_row(8'hFF, 0, 0, '0);
        add_row(OP_CIRCLE, 1, 0, '0);
        add_row(OP_LINE, 1, 0, '0);
        add_row(OP_DATE, 1, 0, '0);
        add_row(OP_RECT, 1, 0, '0);
        add_row(8'h12, 0, 0, '0);
        add_row(8'h34, 0, 0, '0);
        add_row(OP_MIRROR, 1, 1, mir);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_on = directed_rows[i].typed;
            typed_has = directed_rows[i].has_cmd;
            typed_cmd = directed_rows[i].cmd;
            send_byte(directed_rows[i].rx);
        end
        typed_on = 1'b0;
        drain();

        flood_while_held();
        effective_items = 0;
        next_drain = 400;
        held_twice = 1'b0;
        while (effective_items < RANDOM_ITEMS)
        begin
            steady = ((effective_items / 250) % 4 == 2);
            sel = $urandom_range(0, 99);
            op = OP_CIRCLE + 8'($urandom_range(0, 4));
            len = FRAME_BYTES[op - OP_CIRCLE];
            if (sel < 70)
            begin
                send_byte(op);
                repeat ($urandom_range(1, 3))
                    repeat (len) send_byte(frame_byte());
            end
            else if (sel < 80)
            begin
                send_byte(op);
                repeat ($urandom_range(1, len - 1)) send_byte(frame_byte());
            end
            else if (sel < 88)
            begin
                send_byte(OP_CLEAR + 8'($urandom_range(0, 2)));
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if (effective_items >= next_drain)
            begin
                next_drain += 400;
                steady = 1'b0;
                drain();
            end
            if (!held_twice && effective_items >= RANDOM_ITEMS / 2)
            begin
                held_twice = 1'b1;
                flood_while_held();
            end
        end

        steady = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display(
            "%0d bytes sent, %0d commands compared (kinds 0-7: %0d %0d %0d %0d %0d %0d %0d %0d)",
            bytes_sent, cmds_checked, kind_seen[0], kind_seen[1], kind_seen[2],
            kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
        $display("input held back for %0d cycles under output back-pressure", stalled_cycles);
        if (mismatches == 0 && pending_cmds.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/dcd_pkg.sv
src/dcd_frame_ctrl.sv
src/dcd_cmd_decode.sv
src/drawing_command_deframer_top.sv
tb/drawing_command_deframer_top_test.sv
